>>> hdl/c3e_pkg.sv
// Shared types and constants for the 3x3 clamped-edge averaging convolution.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package c3e_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = 11;
  localparam int ROW_W       = 16;
  localparam int PIX_W       = 16;
  localparam int NTAPS       = 9;
  localparam int FRAC_BITS   = 14;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 23;
  // ceil(2^26 / 9): exact floor division by 9 for magnitudes below 2^21
  localparam logic [RECIP_W-1:0] RECIP_NINE = 23'd7456541;

  typedef logic signed [PIX_W-1:0] pix_t;

  typedef enum logic [2:0] {
    CFG_WIDTH       = 3'd0,
    CFG_HEIGHT      = 3'd1,
    CFG_KEEP_TOP    = 3'd2,
    CFG_KEEP_BOTTOM = 3'd3,
    CFG_KEEP_LEFT   = 3'd4,
    CFG_KEEP_RIGHT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             run_last;
    logic             frame_last;
  } res_meta_t;

endpackage

>>> hdl/c3e_line_mem.sv
// Generic single-write, single-read RAM with registered read data (read-old).
// Depends on c3e_pkg for the pixel type and depth.
`timescale 1ns / 1ps

module c3e_line_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [c3e_pkg::COL_W-1:0] waddr,
  input  c3e_pkg::pix_t            wdata,
  input  logic                     re,
  input  logic [c3e_pkg::COL_W-1:0] raddr,
  output c3e_pkg::pix_t            rdata
);

  c3e_pkg::pix_t mem [c3e_pkg::MAX_WIDTH];
  c3e_pkg::pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/c3e_col_cell.sv
// One column cell of the 3x3 window: three pixels, handed on to the next cell
// on every shift. Depends on c3e_pkg.
`timescale 1ns / 1ps

module c3e_col_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  c3e_pkg::pix_t d_in [3],
  output c3e_pkg::pix_t q    [3]
);

  c3e_pkg::pix_t col_r [3];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= d_in;
    end
  end

  assign q = col_r;

endmodule

>>> hdl/c3e_mac.sv
// Filter datapath: nine products, adder tree, Q.14 shift, divide by nine and
// saturation, as a five-stage pipeline with per-stage flow control. Uses c3e_pkg.
`timescale 1ns / 1ps

module c3e_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  c3e_pkg::pix_t      win  [c3e_pkg::NTAPS],
  input  c3e_pkg::pix_t      taps [c3e_pkg::NTAPS],
  input  c3e_pkg::res_meta_t in_meta,
  output logic               out_valid,
  input  logic               out_ready,
  output c3e_pkg::pix_t      out_value,
  output c3e_pkg::res_meta_t out_meta
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  c3e_pkg::res_meta_t m1_r, m2_r, m3_r, m4_r, m5_r;

  logic signed [31:0] prod_r [c3e_pkg::NTAPS];
  logic signed [33:0] part_r [3];
  logic signed [21:0] q_r;
  logic signed [35:0] total;
  logic        [21:0] mag;
  logic        [44:0] scaled_r;
  logic               neg_r;
  logic        [18:0] quot;
  c3e_pkg::pix_t      value_r, value_nxt;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  assign total = 36'(part_r[0]) + 36'(part_r[1]) + 36'(part_r[2]);
  assign mag   = q_r[21] ? 22'(-q_r) : 22'(q_r);
  assign quot  = scaled_r[44:c3e_pkg::RECIP_SHIFT];

  always_comb begin
    if (!neg_r && quot > 19'd32767) begin
      value_nxt = 16'sh7FFF;
    end else if (neg_r && quot > 19'd32768) begin
      value_nxt = 16'sh8000;
    end else if (neg_r) begin
      value_nxt = 16'(-quot);
    end else begin
      value_nxt = 16'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < c3e_pkg::NTAPS; k++) begin
        prod_r[k] <= win[k] * taps[k];
      end
      m1_r <= in_meta;
    end
    if (rdy2) begin
      for (int g = 0; g < 3; g++) begin
        part_r[g] <= 34'(prod_r[3*g]) + 34'(prod_r[3*g+1]) + 34'(prod_r[3*g+2]);
      end
      m2_r <= m1_r;
    end
    if (rdy3) begin
      q_r  <= total[35:c3e_pkg::FRAC_BITS]; // arithmetic shift: floor
      m3_r <= m2_r;
    end
    if (rdy4) begin
      scaled_r <= 45'(mag) * 45'(c3e_pkg::RECIP_NINE);
      neg_r    <= q_r[21];
      m4_r     <= m3_r;
    end
    if (rdy5) begin
      value_r <= value_nxt;
      m5_r    <= m4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_value = value_r;
  assign out_meta  = m5_r;

endmodule

>>> hdl/conv3x3_clamped_edge_average_top.sv
// Streaming 3x3 convolution with clamp-to-edge borders, Q.14 scaling, divide by
// nine and 16-bit saturation. Accepts one item per cycle while in_tready is high.
// A pixel leaves its position through a line-buffer read stage into a chain of
// three window column cells; the window stage then issues one result per cycle,
// while the pipeline takes it, into a five-stage arithmetic pipeline, so a pixel
// that completes n outputs (up to four, at the right edge and bottom row) stalls
// later pixels until its last output is issued. A tap transfer waits until every
// result of earlier pixels has entered the arithmetic pipeline, so new taps never
// reach older pixels. Registers may only be written while no pixel is in flight.
// Depends on c3e_pkg, c3e_line_mem, c3e_col_cell and c3e_mac.
`timescale 1ns / 1ps

module conv3x3_clamped_edge_average_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] tap_index, [19:4] sample_value, [23:20] zero
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] result_value, [31:16] out_row, [41:32] out_col
  output logic [1:0]  out_tlast,  // [0] run_last, [1] frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = c3e_pkg::COL_W;
  localparam int RW = c3e_pkg::ROW_W;
  localparam int WW = c3e_pkg::WID_W;

  // configuration
  logic [WW-1:0] width_r;
  logic [RW-1:0] height_r;
  logic keep_top_r, keep_bottom_r, keep_left_r, keep_right_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= WW'(c3e_pkg::MAX_WIDTH);
      height_r      <= 16'd1024;
      keep_top_r    <= 1'b1;
      keep_bottom_r <= 1'b1;
      keep_left_r   <= 1'b1;
      keep_right_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (c3e_pkg::cfg_idx_t'(cfg_index))
        c3e_pkg::CFG_WIDTH:       width_r       <= cfg_data[WW-1:0];
        c3e_pkg::CFG_HEIGHT:      height_r      <= cfg_data;
        c3e_pkg::CFG_KEEP_TOP:    keep_top_r    <= cfg_data[0];
        c3e_pkg::CFG_KEEP_BOTTOM: keep_bottom_r <= cfg_data[0];
        c3e_pkg::CFG_KEEP_LEFT:   keep_left_r   <= cfg_data[0];
        c3e_pkg::CFG_KEEP_RIGHT:  keep_right_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input transfer
  logic in_hs, pix_hs, tap_hs;
  logic [3:0] tap_index;
  c3e_pkg::pix_t sample;

  assign tap_index = in_tdata[3:0];
  assign sample    = in_tdata[19:4];
  assign in_hs  = in_tvalid && in_tready;
  assign pix_hs = in_hs && in_tuser[0];
  assign tap_hs = in_hs && !in_tuser[0];

  c3e_pkg::pix_t taps_r [c3e_pkg::NTAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < c3e_pkg::NTAPS; k++) taps_r[k] <= '0;
    end else if (tap_hs && tap_index < 4'(c3e_pkg::NTAPS)) begin
      taps_r[tap_index] <= sample;
    end
  end

  // raster position
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic          col_wrap;
  logic [RW:0]   row_a, i_inc;
  logic [RW-1:0] cur_i;
  logic [CW-1:0] cur_j;
  logic [WW-1:0] j_inc;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (width_r > WW'(c3e_pkg::MAX_WIDTH)) begin
      w_eff = WW'(c3e_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff    = (height_r == '0) ? RW'(1) : height_r;
    col_wrap = {1'b0, in_col_r} >= w_eff;
    row_a    = col_wrap ? {1'b0, in_row_r} + 17'd1 : {1'b0, in_row_r};
    cur_i    = (row_a >= {1'b0, h_eff}) ? '0 : row_a[RW-1:0];
    cur_j    = col_wrap ? '0 : in_col_r;
    j_inc    = {1'b0, cur_j} + WW'(1);
    i_inc    = {1'b0, cur_i} + 17'd1;
    if (j_inc >= w_eff) begin
      in_col_nxt = '0;
      in_row_nxt = (i_inc >= {1'b0, h_eff}) ? '0 : i_inc[RW-1:0];
    end else begin
      in_col_nxt = j_inc[CW-1:0];
      in_row_nxt = cur_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else if (pix_hs) begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  // candidate outputs completed by this pixel, borders already filtered
  logic i_ge1, i_ge2, i_is1, i_last, j_ge1, j_ge2, j_is1, j_last;
  logic top_a_drop, top_b_drop, left_a_drop, left_b_drop;
  logic [3:0] cand_mask;

  always_comb begin
    i_ge1  = cur_i != '0;
    i_ge2  = cur_i >= RW'(2);
    i_is1  = cur_i == RW'(1);
    i_last = cur_i == h_eff - RW'(1);
    j_ge1  = cur_j != '0;
    j_ge2  = cur_j >= CW'(2);
    j_is1  = cur_j == CW'(1);
    j_last = {1'b0, cur_j} == w_eff - WW'(1);
    top_a_drop  = i_is1 && !keep_top_r;
    top_b_drop  = !i_ge1 && !keep_top_r;
    left_a_drop = j_is1 && !keep_left_r;
    left_b_drop = !j_ge1 && !keep_left_r;
    cand_mask[0] = i_ge1 && j_ge1 && !top_a_drop && !left_a_drop;
    cand_mask[1] = i_ge1 && j_last && !top_a_drop && !left_b_drop && keep_right_r;
    cand_mask[2] = i_last && j_ge1 && !top_b_drop && keep_bottom_r && !left_a_drop;
    cand_mask[3] = i_last && j_last && !top_b_drop && keep_bottom_r && !left_b_drop &&
                   keep_right_r;
  end

  // line buffer: two rows, bank chosen by row parity
  c3e_pkg::pix_t rd0, rd1;

  c3e_line_mem u_line0 (
    .clk   (clk),
    .we    (pix_hs && !cur_i[0]),
    .waddr (cur_j),
    .wdata (sample),
    .re    (pix_hs),
    .raddr (cur_j),
    .rdata (rd0)
  );

  c3e_line_mem u_line1 (
    .clk   (clk),
    .we    (pix_hs && cur_i[0]),
    .waddr (cur_j),
    .wdata (sample),
    .re    (pix_hs),
    .raddr (cur_j),
    .rdata (rd1)
  );

  // read stage
  logic          s1_v_r;
  c3e_pkg::pix_t s1_px_r;
  logic          s1_bank_r;
  logic [3:0]    s1_mask_r;
  logic          s1_ige1_r, s1_ige2_r, s1_jge1_r, s1_jge2_r, s1_fend_r;
  logic [RW-1:0] s1_rowa_r, s1_rowb_r;
  logic [CW-1:0] s1_cola_r, s1_colb_r;
  logic          w_free;
  logic          s1_free;

  // a tap waits until the window has handed all earlier results to the pipeline
  assign s1_free   = !s1_v_r || w_free;
  assign in_tready = in_tuser[0] ? s1_free : (!s1_v_r && w_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= pix_hs;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_hs) begin
      s1_px_r   <= sample;
      s1_bank_r <= cur_i[0];
      s1_mask_r <= cand_mask;
      s1_ige1_r <= i_ge1;
      s1_ige2_r <= i_ge2;
      s1_jge1_r <= j_ge1;
      s1_jge2_r <= j_ge2;
      s1_fend_r <= i_last && j_last;
      s1_rowa_r <= cur_i - RW'(1) - RW'(!keep_top_r);
      s1_rowb_r <= cur_i - RW'(!keep_top_r);
      s1_cola_r <= cur_j - CW'(1) - CW'(!keep_left_r);
      s1_colb_r <= cur_j - CW'(!keep_left_r);
    end
  end

  // window stage: column cells, newest column in cell 2
  logic          shift_en;
  c3e_pkg::pix_t new_col [3];
  c3e_pkg::pix_t col0 [3], col1 [3], col2 [3];

  assign new_col[0] = s1_bank_r ? rd1 : rd0; // two rows up
  assign new_col[1] = s1_bank_r ? rd0 : rd1; // previous row
  assign new_col[2] = s1_px_r;

  c3e_col_cell u_cell2 (.clk(clk), .shift_en(shift_en), .d_in(new_col), .q(col2));
  c3e_col_cell u_cell1 (.clk(clk), .shift_en(shift_en), .d_in(col2),    .q(col1));
  c3e_col_cell u_cell0 (.clk(clk), .shift_en(shift_en), .d_in(col1),    .q(col0));

  logic [3:0]    pend_r;
  logic          w_ige1_r, w_ige2_r, w_jge1_r, w_jge2_r, w_fend_r;
  logic [RW-1:0] w_rowa_r, w_rowb_r;
  logic [CW-1:0] w_cola_r, w_colb_r;
  logic [3:0]    sel;
  logic          issue_last, issue_hs, mac_ready;
  logic          row_b, col_b;
  logic [1:0]    wr [3];
  logic [1:0]    wc [3];
  c3e_pkg::pix_t win [c3e_pkg::NTAPS];
  c3e_pkg::res_meta_t issue_meta;

  assign sel        = pend_r & (~pend_r + 4'd1);
  assign issue_last = (pend_r & ~sel) == 4'd0;
  assign issue_hs   = (pend_r != 4'd0) && mac_ready;
  assign w_free     = (pend_r == 4'd0) || (issue_hs && issue_last);
  assign shift_en   = s1_v_r && w_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (shift_en) begin
      pend_r <= s1_mask_r;
    end else if (issue_hs) begin
      pend_r <= pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      w_ige1_r <= s1_ige1_r;
      w_ige2_r <= s1_ige2_r;
      w_jge1_r <= s1_jge1_r;
      w_jge2_r <= s1_jge2_r;
      w_fend_r <= s1_fend_r;
      w_rowa_r <= s1_rowa_r;
      w_rowb_r <= s1_rowb_r;
      w_cola_r <= s1_cola_r;
      w_colb_r <= s1_colb_r;
    end
  end

  // clamped window addressing for the selected output
  always_comb begin
    row_b = sel[2] || sel[3];
    col_b = sel[1] || sel[3];
    if (row_b) begin
      wr[0] = w_ige1_r ? 2'd1 : 2'd2;
      wr[1] = 2'd2;
    end else begin
      wr[0] = w_ige2_r ? 2'd0 : 2'd1;
      wr[1] = 2'd1;
    end
    wr[2] = 2'd2;
    if (col_b) begin
      wc[0] = w_jge1_r ? 2'd1 : 2'd2;
      wc[1] = 2'd2;
    end else begin
      wc[0] = w_jge2_r ? 2'd0 : 2'd1;
      wc[1] = 2'd1;
    end
    wc[2] = 2'd2;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        case (wc[b])
          2'd0:    win[a*3+b] = col0[wr[a]];
          2'd1:    win[a*3+b] = col1[wr[a]];
          default: win[a*3+b] = col2[wr[a]];
        endcase
      end
    end
    issue_meta.row        = row_b ? w_rowb_r : w_rowa_r;
    issue_meta.col        = col_b ? w_colb_r : w_cola_r;
    issue_meta.run_last   = issue_last;
    issue_meta.frame_last = issue_last && w_fend_r;
  end

  c3e_pkg::pix_t      res_value;
  c3e_pkg::res_meta_t res_meta;

  c3e_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pend_r != 4'd0),
    .in_ready  (mac_ready),
    .win       (win),
    .taps      (taps_r),
    .in_meta   (issue_meta),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (res_value),
    .out_meta  (res_meta)
  );

  assign out_tdata = {6'd0, res_meta.col, res_meta.row, res_value};
  assign out_tlast = {res_meta.frame_last, res_meta.run_last};

endmodule
